### rtl/core/gha_pkg.sv
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types and constants for the generational handle allocator: slot
// table geometry, handle field layout, operation codes and the structs that
// pass between the engine and the top level.
// ----------------------------------------------------------------------------
package gha_pkg;

  // Slot table geometry
  localparam int unsigned SLOTS  = 1024;
  localparam int unsigned IDX_W  = $clog2(SLOTS);
  localparam int unsigned CNT_W  = 11;          // live / opened / limit fields
  localparam int unsigned HDL_W  = 32;
  localparam int unsigned SIDX_W = 16;          // index field of a handle
  localparam int unsigned GEN_W  = 15;

  localparam logic [CNT_W-1:0]  SLOTS_CNT   = CNT_W'(SLOTS);
  localparam logic [SIDX_W-1:0] SLOTS_SIDX  = SIDX_W'(SLOTS);
  localparam logic [SIDX_W-1:0] LIST_END    = '1;
  localparam logic [HDL_W-1:0]  NULL_HANDLE = '1;
  localparam logic [GEN_W-1:0]  GEN_ROLL    = '1;
  localparam logic [CNT_W-1:0]  LIMIT_RST   = 11'd1024;

  // Handle layout: index in the low bits, then generation, then invalid flag
  localparam int unsigned GEN_LSB = SIDX_W;
  localparam int unsigned GEN_MSB = SIDX_W + GEN_W - 1;
  localparam int unsigned INV_BIT = HDL_W - 1;

  typedef enum logic [1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_CHECK   = 2'd2,
    MODE_NEXT    = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic [HDL_W-1:0]   handle;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0]   high_water;
    logic [CNT_W-1:0]   live_count;
    logic               ok;
    logic [HDL_W-1:0]   handle;
  } res_t;

endpackage

### rtl/core/gha_ram.sv
// ----------------------------------------------------------------------------
// gha_ram
// Generic single-write, single-read synchronous RAM. Read data is registered
// and holds its value while no read is issued.
// ----------------------------------------------------------------------------
module gha_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/gha_engine.sv
// ----------------------------------------------------------------------------
// gha_engine
// Slot table sequencer: reads the slot word for allocate, release and check
// and writes it back modified for allocate and release; walks the table one
// slot a cycle for the next-live scan; holds free list head and slot counters.
// ----------------------------------------------------------------------------
module gha_engine (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_valid,
  input  gha_pkg::cmd_t         cmd,
  output logic                  cmd_ready,
  input  logic [gha_pkg::CNT_W-1:0] slot_limit,
  output logic                  res_valid,
  output gha_pkg::res_t         res,
  input  logic                  res_ready
);
  import gha_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN
  } state_t;

  state_t              state_r, state_nxt;
  mode_t               mode_r, mode_nxt;
  logic [HDL_W-1:0]    hdl_r, hdl_nxt;
  logic [SIDX_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]    opened_r, opened_nxt;
  logic [CNT_W-1:0]    alloc_r, alloc_nxt;
  logic [CNT_W-1:0]    scan_r, scan_nxt;
  logic                pend_r, pend_nxt;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [HDL_W-1:0]    ram_wdata;
  logic                ram_re;
  logic [IDX_W-1:0]    ram_raddr;
  logic [HDL_W-1:0]    ram_rdata;

  logic [CNT_W-1:0]    lim;
  logic                use_list;
  logic [SIDX_W-1:0]   head_clamp;
  logic [SIDX_W-1:0]   idx;
  logic                hdl_valid;
  logic [GEN_W-1:0]    gen_inc;
  logic [GEN_W-1:0]    gen_new;
  logic [SIDX_W:0]     scan_start;
  logic [SIDX_W-1:0]   cmd_idx;

  gha_ram #(
    .WIDTH (HDL_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Decode of the slot word and the held item
  always_comb begin
    lim        = (slot_limit > SLOTS_CNT) ? SLOTS_CNT : slot_limit;
    use_list   = (head_r != LIST_END) && (head_r < SLOTS_SIDX);
    head_clamp = (head_r < SLOTS_SIDX) ? head_r : LIST_END;
    idx        = hdl_r[SIDX_W-1:0];
    hdl_valid  = (idx < SIDX_W'(opened_r)) && !ram_rdata[INV_BIT] &&
                 (ram_rdata[GEN_MSB:GEN_LSB] == hdl_r[GEN_MSB:GEN_LSB]);
    gen_inc    = ram_rdata[GEN_MSB:GEN_LSB] + GEN_W'(1);
    gen_new    = (gen_inc == GEN_ROLL) ? '0 : gen_inc;
    cmd_idx    = cmd.handle[SIDX_W-1:0];
    scan_start = (cmd_idx == LIST_END) ? '0 : ({1'b0, cmd_idx} + (SIDX_W+1)'(1));
  end

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    hdl_nxt    = hdl_r;
    head_nxt   = head_r;
    opened_nxt = opened_r;
    alloc_nxt  = alloc_r;
    scan_nxt   = scan_r;
    pend_nxt   = pend_r;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    res_valid  = 1'b0;
    res        = '0;
    cmd_ready  = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        // Take the item and start the slot read, except for next-live
        if (cmd_valid) begin
          mode_nxt  = cmd.mode;
          hdl_nxt   = cmd.handle;
          ram_re    = (cmd.mode != MODE_NEXT);
          ram_raddr = (cmd.mode == MODE_ALLOC) ? head_r[IDX_W-1:0]
                                               : cmd.handle[IDX_W-1:0];
          if (cmd.mode == MODE_NEXT) begin
            state_nxt = S_SCAN;
            pend_nxt  = 1'b0;
            scan_nxt  = (scan_start < (SIDX_W+1)'(opened_r)) ?
                        scan_start[CNT_W-1:0] : opened_r;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end

      S_EXEC: begin
        res_valid = 1'b1;
        case (mode_r)
          MODE_ALLOC: begin
            if (use_list) begin
              // Pop the free list and bump the generation
              ram_we     = res_ready;
              ram_waddr  = head_r[IDX_W-1:0];
              ram_wdata  = {1'b0, gen_new, head_r};
              res.handle = {1'b0, gen_new, head_r};
              res.ok     = 1'b1;
              alloc_nxt  = alloc_r + CNT_W'(1);
              head_nxt   = ram_rdata[SIDX_W-1:0];
            end else if (opened_r >= lim) begin
              res.handle = NULL_HANDLE;
            end else begin
              // Open a fresh slot at generation zero
              ram_we     = res_ready;
              ram_waddr  = opened_r[IDX_W-1:0];
              ram_wdata  = HDL_W'(opened_r);
              res.handle = HDL_W'(opened_r);
              res.ok     = 1'b1;
              alloc_nxt  = alloc_r + CNT_W'(1);
              opened_nxt = opened_r + CNT_W'(1);
            end
          end
          MODE_RELEASE: begin
            res.handle = hdl_r;
            res.ok     = hdl_valid;
            if (hdl_valid) begin
              // Mark invalid, keep generation, push on the free list
              ram_we    = res_ready;
              ram_waddr = idx[IDX_W-1:0];
              ram_wdata = {1'b1, ram_rdata[GEN_MSB:GEN_LSB], head_clamp};
              head_nxt  = idx;
              alloc_nxt = alloc_r - CNT_W'(1);
            end
          end
          MODE_CHECK: begin
            res.handle = hdl_r;
            res.ok     = hdl_valid;
          end
          default: begin
            res.handle = NULL_HANDLE;
          end
        endcase
        res.live_count = alloc_nxt;
        res.high_water = opened_nxt;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end else begin
          head_nxt   = head_r;
          opened_nxt = opened_r;
          alloc_nxt  = alloc_r;
        end
      end

      S_SCAN: begin
        res.live_count = alloc_r;
        res.high_water = opened_r;
        if (pend_r && !ram_rdata[INV_BIT]) begin
          // Live slot found: hold until the result is taken
          res_valid  = 1'b1;
          res.handle = ram_rdata;
          res.ok     = 1'b1;
          if (res_ready) begin
            state_nxt = S_IDLE;
          end
        end else if (scan_r < opened_r) begin
          // Advance to the next slot
          ram_re    = 1'b1;
          ram_raddr = scan_r[IDX_W-1:0];
          scan_nxt  = scan_r + CNT_W'(1);
          pend_nxt  = 1'b1;
        end else begin
          // End of opened slots
          res_valid  = 1'b1;
          res.handle = HDL_W'(opened_r);
          if (res_ready) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= LIST_END;
      opened_r <= '0;
      alloc_r  <= '0;
      pend_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      opened_r <= opened_nxt;
      alloc_r  <= alloc_nxt;
      pend_r   <= pend_nxt;
    end
  end

  // Item payload
  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    hdl_r  <= hdl_nxt;
    scan_r <= scan_nxt;
  end

endmodule

### rtl/core/generational_handle_allocator_core.sv
// ----------------------------------------------------------------------------
// generational_handle_allocator_core
// Slot map handing out 32-bit generational handles, with a linked free list,
// a high-water mark and a forward scan for live slots.
//
//   channel  | direction | contents
//   ---------+-----------+----------------------------------------------------
//   in_      | slave     | tuser: mode; tdata: handle
//   out_     | master    | tdata: handle, ok, live count, high water
//   cfg_     | write     | slot limit (11 bits)
//
// Allocate, release and check start with one slot RAM read; allocate and
// release then modify and write back. Next-live reads the opened slots one
// after another through the single read port of the slot RAM.
// Reset clears the counters and the free list head; the slot RAM needs no
// clearing pass since data read from unopened slots is never used.
// One result register sits on the output; the engine waits at the end of an
// item while that register is full and not being emptied.
// ----------------------------------------------------------------------------
module generational_handle_allocator_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [31:0]               in_tdata,   // [31:0] in_handle
  input  logic [1:0]                in_tuser,   // [1:0] mode
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [55:0]               out_tdata,  // [31:0] out_handle, [32] ok,
                                                // [43:33] live_count,
                                                // [54:44] high_water, [55] zero
  input  logic                      cfg_wr_en,
  input  logic [10:0]               cfg_wr_data // [10:0] slot_limit
);
  import gha_pkg::*;

  logic [CNT_W-1:0] slot_limit_r;
  cmd_t             cmd;
  logic             res_valid;
  logic             res_ready;
  res_t             res;
  logic             out_valid_r;
  res_t             out_res_r;

  // Slot limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_limit_r <= LIMIT_RST;
    end else if (cfg_wr_en) begin
      slot_limit_r <= cfg_wr_data;
    end
  end

  assign cmd.mode   = mode_t'(in_tuser);
  assign cmd.handle = in_tdata;

  gha_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (in_tvalid),
    .cmd        (cmd),
    .cmd_ready  (in_tready),
    .slot_limit (slot_limit_r),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready)
  );

  // Output register: load when empty or being emptied
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r};

endmodule

### rtl/core/gha_checker.sv
// ----------------------------------------------------------------------------
// gha_checker
// Port-level checks for the generational handle allocator, bound to the top.
// ----------------------------------------------------------------------------
module gha_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata
);
  import gha_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // One item at a time: no item is taken in the cycle after one was taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after an accepted item");

  // Live slots never outnumber opened slots
  a_live_le_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[43:33] <= out_tdata[54:44])
    else $error("live count above high water");

  // The table never opens more slots than it has
  a_open_le_slots: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[54:44] <= SLOTS_CNT)
    else $error("high water above table size");

endmodule

bind generational_handle_allocator_core gha_checker u_gha_checker (.*);
